// ----- rtl/quad_lane_bit_pair_interleaver_defines.svh -----
// ----------------------------------------------------------------------------
// Quad lane bit pair interleaver: shared assertion macros
// Each macro expands to one labeled concurrent assertion that reports by $error.
// ----------------------------------------------------------------------------
`ifndef QUAD_LANE_BIT_PAIR_INTERLEAVER_DEFINES_SVH
`define QUAD_LANE_BIT_PAIR_INTERLEAVER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define QLBPI_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define QLBPI_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/qlbpi_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Quad lane bit pair interleaver package
// Shared constants, payload types, command codes and controller types.
// ----------------------------------------------------------------------------
package qlbpi_pkg;

	localparam int LANES          = 4;
	localparam int LANE_SEL_W     = $clog2(LANES);
	localparam int BYTE_W         = 8;
	localparam int PAIR_W         = 2;
	localparam int LANE_DEPTH_DEF = 1024;
	localparam int PAD_DEPTH_DEF  = 16;

	typedef enum logic [1:0] {
		MODE_CLEAR = 2'd0,
		MODE_DATA  = 2'd1,
		MODE_PAD   = 2'd2,
		MODE_EMIT  = 2'd3
	} mode_t;

	typedef struct packed {
		logic [1:0]            mode;
		logic [LANE_SEL_W-1:0] lane;
		logic [BYTE_W-1:0]     value;
	} req_t;

	typedef struct packed {
		logic [BYTE_W-1:0] out_byte;
		logic              group_end;
		logic              frame_end;
	} rsp_t;

	// How the byte of one lane is obtained for the current index.
	typedef enum logic [1:0] {
		KIND_DIRECT = 2'd0,
		KIND_DATA   = 2'd1,
		KIND_PAD    = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		ST_IDLE    = 3'd0,
		ST_LANE    = 3'd1,
		ST_CLASS   = 3'd2,
		ST_MOD     = 3'd3,
		ST_PADRD   = 3'd4,
		ST_CAPTURE = 3'd5,
		ST_LOAD    = 3'd6
	} state_t;

	typedef struct packed {
		logic lane_clr;
		logic lane_inc;
		logic lead_ld;
		logic class_en;
		logic mod_step;
		logic pad_rd;
		logic capture;
		logic load;
	} ctl_t;

	typedef struct packed {
		logic  emit_ok;
		logic  lane_last;
		kind_t kind;
		logic  mod_last;
		logic  obuf_free;
	} stat_t;

endpackage

// ----- rtl/qlbpi_stream_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Quad lane bit pair interleaver stream interface
// Valid and ready handshake with a typed payload; a transfer happens at a
// rising edge where valid and ready are both high.
// ----------------------------------------------------------------------------
interface qlbpi_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// ----- rtl/qlbpi_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Quad lane bit pair interleaver generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module qlbpi_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;
endmodule

// ----- rtl/qlbpi_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Quad lane bit pair interleaver controller
// Sequences an emit over the four lanes: classify, optional remainder
// iterations, memory read, capture, then hand-off to the output buffer.
// ----------------------------------------------------------------------------
module qlbpi_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic [1:0]       in_mode,
	input  qlbpi_pkg::stat_t stat,
	output qlbpi_pkg::ctl_t  ctl,
	output logic             in_ready
);
	import qlbpi_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid && in_mode == MODE_EMIT && stat.emit_ok) begin
					state_d = ST_LANE;
				end
			end
			ST_LANE: begin
				state_d = ST_CLASS;
			end
			ST_CLASS: begin
				case (stat.kind)
					KIND_DATA: state_d = ST_CAPTURE;
					KIND_PAD:  state_d = ST_MOD;
					default:   state_d = stat.lane_last ? ST_LOAD : ST_LANE;
				endcase
			end
			ST_MOD: begin
				if (stat.mod_last) begin
					state_d = ST_PADRD;
				end
			end
			ST_PADRD: begin
				state_d = ST_CAPTURE;
			end
			ST_CAPTURE: begin
				state_d = stat.lane_last ? ST_LOAD : ST_LANE;
			end
			ST_LOAD: begin
				if (stat.obuf_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		ctl      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready     = 1'b1;
				ctl.lane_clr = 1'b1;
			end
			ST_LANE: begin
				ctl.lead_ld = 1'b1;
			end
			ST_CLASS: begin
				ctl.class_en = 1'b1;
				ctl.lane_inc = (stat.kind inside {KIND_DIRECT}) && !stat.lane_last;
			end
			ST_MOD: begin
				ctl.mod_step = 1'b1;
			end
			ST_PADRD: begin
				ctl.pad_rd = 1'b1;
			end
			ST_CAPTURE: begin
				ctl.capture  = 1'b1;
				ctl.lane_inc = !stat.lane_last;
			end
			ST_LOAD: begin
				ctl.load = stat.obuf_free;
			end
			default: begin
				ctl = '0;
			end
		endcase
	end
endmodule

// ----- rtl/qlbpi_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Quad lane bit pair interleaver datapath
// Lane and padding memories, lengths, the serial remainder unit, the gather
// registers and the four-byte output buffer.
// ----------------------------------------------------------------------------
module qlbpi_dp #(
	parameter int LANE_DEPTH = qlbpi_pkg::LANE_DEPTH_DEF,
	parameter int PAD_DEPTH  = qlbpi_pkg::PAD_DEPTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             take,
	input  qlbpi_pkg::req_t                  req,
	input  qlbpi_pkg::ctl_t                  ctl,
	output qlbpi_pkg::stat_t                 stat,
	output qlbpi_pkg::rsp_t                  rsp,
	output logic                             rsp_valid,
	input  logic                             rsp_ready
);
	import qlbpi_pkg::*;

	localparam int LEN_W   = $clog2(LANE_DEPTH + 1);
	localparam int LANE_AW = (LANE_DEPTH > 1) ? $clog2(LANE_DEPTH) : 1;
	localparam int PL_W    = $clog2(PAD_DEPTH + 1);
	localparam int PAD_AW  = (PAD_DEPTH > 1) ? $clog2(PAD_DEPTH) : 1;
	localparam int STEP_W  = (LEN_W > 1) ? $clog2(LEN_W) : 1;

	logic [LEN_W-1:0]      lane_len_q [LANES];
	logic [PL_W-1:0]       pad_len_q [LANES];
	logic [LANES-1:0]      present_q;
	logic [LEN_W-1:0]      longest_q;
	logic [LEN_W-1:0]      read_idx_q;
	logic [BYTE_W-1:0]     fill_q;
	logic [LANE_SEL_W-1:0] lane_q;
	logic [LEN_W-1:0]      lead_q;
	logic                  sel_pad_q;
	logic [LEN_W-1:0]      div_q;
	logic [PL_W-1:0]       divisor_q;
	logic [PL_W-1:0]       rem_q;
	logic [STEP_W-1:0]     step_q;
	logic [BYTE_W-1:0]     gather_q [LANES];
	logic [BYTE_W-1:0]     obuf_q [LANES];
	logic [LANE_SEL_W-1:0] ocnt_q;
	logic                  ovalid_q;
	logic                  olast_q;

	logic [LEN_W-1:0]  new_len;
	logic              data_room;
	logic              pad_room;
	logic [LEN_W:0]    diff;
	kind_t             kind;
	logic [BYTE_W-1:0] direct_byte;
	logic [PL_W:0]     rem_ext;
	logic [PL_W-1:0]   rem_next;
	logic [BYTE_W-1:0] lane_rdata;
	logic [BYTE_W-1:0] pad_rdata;
	logic [BYTE_W-1:0] woven [LANES];
	logic              is_last;
	logic              out_xfer;

	assign new_len   = LEN_W'(lane_len_q[req.lane] + 1'b1);
	assign data_room = lane_len_q[req.lane] < LEN_W'(LANE_DEPTH);
	assign pad_room  = pad_len_q[req.lane] < PL_W'(PAD_DEPTH);

	// A borrow out of the subtraction means the index still lies in the lead-in.
	assign diff = {1'b0, read_idx_q} - {1'b0, lead_q};

	always_comb begin
		if (!present_q[lane_q]) begin
			kind = KIND_DIRECT;
		end else if (diff[LEN_W]) begin
			kind = (pad_len_q[lane_q] != '0) ? KIND_PAD : KIND_DIRECT;
		end else begin
			kind = KIND_DATA;
		end
	end

	// Absent lanes take the first padding byte of lane 0, or zero if lane 0 has none;
	// a present lane with no padding frame reads zero in its lead-in.
	assign direct_byte = (!present_q[lane_q] && pad_len_q[0] != '0) ? fill_q : '0;

	// One restoring step of the remainder of the read index by the frame length.
	assign rem_ext  = {rem_q, div_q[LEN_W-1]};
	assign rem_next = (rem_ext >= {1'b0, divisor_q}) ?
		PL_W'(rem_ext - {1'b0, divisor_q}) : rem_ext[PL_W-1:0];

	assign is_last  = ({1'b0, read_idx_q} + 1'b1) == {1'b0, longest_q};
	assign out_xfer = ovalid_q && rsp_ready;

	always_comb begin
		for (int j = 0; j < LANES; j++) begin
			woven[j] = '0;
			for (int k = 0; k < LANES; k++) begin
				woven[j][PAIR_W*k +: PAIR_W] = gather_q[k][BYTE_W-PAIR_W-PAIR_W*j +: PAIR_W];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < LANES; k++) begin
				lane_len_q[k] <= '0;
				pad_len_q[k]  <= '0;
			end
			present_q  <= '0;
			longest_q  <= '0;
			read_idx_q <= '0;
		end else begin
			if (take) begin
				case (req.mode)
					MODE_CLEAR: begin
						for (int k = 0; k < LANES; k++) begin
							lane_len_q[k] <= '0;
							pad_len_q[k]  <= '0;
						end
						present_q  <= '0;
						longest_q  <= '0;
						read_idx_q <= '0;
					end
					MODE_DATA: begin
						present_q[req.lane] <= 1'b1;
						if (data_room) begin
							lane_len_q[req.lane] <= new_len;
							if (new_len > longest_q) begin
								longest_q <= new_len;
							end
						end
					end
					MODE_PAD: begin
						present_q[req.lane] <= 1'b1;
						if (pad_room) begin
							pad_len_q[req.lane] <= PL_W'(pad_len_q[req.lane] + 1'b1);
						end
					end
					default: begin
					end
				endcase
			end
			if (ctl.load) begin
				read_idx_q <= LEN_W'(read_idx_q + 1'b1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lane_q   <= '0;
			step_q   <= '0;
			ocnt_q   <= '0;
			ovalid_q <= 1'b0;
		end else begin
			if (ctl.lane_clr) begin
				lane_q <= '0;
			end else if (ctl.lane_inc) begin
				lane_q <= LANE_SEL_W'(lane_q + 1'b1);
			end
			if (ctl.class_en && kind == KIND_PAD) begin
				step_q <= '0;
			end else if (ctl.mod_step) begin
				step_q <= STEP_W'(step_q + 1'b1);
			end
			if (ctl.load) begin
				ovalid_q <= 1'b1;
				ocnt_q   <= '0;
			end else if (out_xfer) begin
				if (ocnt_q == LANE_SEL_W'(LANES - 1)) begin
					ovalid_q <= 1'b0;
					ocnt_q   <= '0;
				end else begin
					ocnt_q <= LANE_SEL_W'(ocnt_q + 1'b1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && req.mode == MODE_PAD && req.lane == '0 && pad_len_q[0] == '0) begin
			fill_q <= req.value;
		end
		if (ctl.lead_ld) begin
			lead_q <= longest_q - lane_len_q[lane_q];
		end
		if (ctl.class_en) begin
			sel_pad_q <= (kind == KIND_PAD);
			if (kind == KIND_DIRECT) begin
				gather_q[lane_q] <= direct_byte;
			end
			if (kind == KIND_PAD) begin
				div_q     <= read_idx_q;
				divisor_q <= pad_len_q[lane_q];
				rem_q     <= '0;
			end
		end
		if (ctl.mod_step) begin
			rem_q <= rem_next;
			div_q <= {div_q[LEN_W-2:0], 1'b0};
		end
		if (ctl.capture) begin
			gather_q[lane_q] <= sel_pad_q ? pad_rdata : lane_rdata;
		end
		if (ctl.load) begin
			obuf_q  <= woven;
			olast_q <= is_last;
		end
	end

	qlbpi_ram #(
		.WIDTH (BYTE_W),
		.DEPTH (LANES << LANE_AW)
	) u_lane_ram (
		.clk   (clk),
		.we    (take && req.mode == MODE_DATA && data_room),
		.waddr ({req.lane, lane_len_q[req.lane][LANE_AW-1:0]}),
		.wdata (req.value),
		.re    (ctl.class_en && kind == KIND_DATA),
		.raddr ({lane_q, diff[LANE_AW-1:0]}),
		.rdata (lane_rdata)
	);

	qlbpi_ram #(
		.WIDTH (BYTE_W),
		.DEPTH (LANES << PAD_AW)
	) u_pad_ram (
		.clk   (clk),
		.we    (take && req.mode == MODE_PAD && pad_room),
		.waddr ({req.lane, pad_len_q[req.lane][PAD_AW-1:0]}),
		.wdata (req.value),
		.re    (ctl.pad_rd),
		.raddr ({lane_q, rem_q[PAD_AW-1:0]}),
		.rdata (pad_rdata)
	);

	assign stat.emit_ok   = read_idx_q < longest_q;
	assign stat.lane_last = lane_q == LANE_SEL_W'(LANES - 1);
	assign stat.kind      = kind;
	assign stat.mod_last  = step_q == STEP_W'(LEN_W - 1);
	assign stat.obuf_free = !ovalid_q;

	assign rsp.out_byte  = obuf_q[ocnt_q];
	assign rsp.group_end = ocnt_q == LANE_SEL_W'(LANES - 1);
	assign rsp.frame_end = (ocnt_q == LANE_SEL_W'(LANES - 1)) && olast_q;
	assign rsp_valid     = ovalid_q;
endmodule

// ----- rtl/quad_lane_bit_pair_interleaver.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Quad lane bit pair interleaver
// Clear, data append and padding append commands complete in the transfer cycle.
// An emit walks each lane through the lane and classify states; a data read adds
// a capture, a padding read adds the remainder iterations, a pad read and a capture.
// The padding path is bound by the one-bit-per-cycle remainder unit.
// Four result transfers follow; the next command is taken while they drain.
// Reset clears all lengths, presence bits and the read index; memories are kept.
// ----------------------------------------------------------------------------
module quad_lane_bit_pair_interleaver #(
	parameter int LANE_DEPTH = qlbpi_pkg::LANE_DEPTH_DEF,
	parameter int PAD_DEPTH  = qlbpi_pkg::PAD_DEPTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	qlbpi_stream_if.sink          cmd,
	qlbpi_stream_if.source        res
);
	import qlbpi_pkg::*;

	ctl_t  ctl;
	stat_t stat;
	req_t  req;
	rsp_t  rsp;
	logic  take;
	logic  in_ready;
	logic  rsp_valid;

	assign req       = cmd.payload;
	assign cmd.ready = in_ready;
	assign take      = cmd.valid && in_ready;

	qlbpi_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (cmd.valid),
		.in_mode  (req.mode),
		.stat     (stat),
		.ctl      (ctl),
		.in_ready (in_ready)
	);

	qlbpi_dp #(
		.LANE_DEPTH (LANE_DEPTH),
		.PAD_DEPTH  (PAD_DEPTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.req       (req),
		.ctl       (ctl),
		.stat      (stat),
		.rsp       (rsp),
		.rsp_valid (rsp_valid),
		.rsp_ready (res.ready)
	);

	assign res.valid   = rsp_valid;
	assign res.payload = rsp;
endmodule

// ----- rtl/qlbpi_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Quad lane bit pair interleaver checker
// Watches the result port for group framing and output stability.
// ----------------------------------------------------------------------------
`include "quad_lane_bit_pair_interleaver_defines.svh"

module qlbpi_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       res_valid,
	input logic       res_ready,
	input logic [7:0] out_byte,
	input logic       group_end,
	input logic       frame_end
);
	// A held result must not change while the sink stalls.
	`QLBPI_ASSERT_NEXT(a_res_hold, clk, arst_n, res_valid && !res_ready, res_valid && $stable(out_byte) && $stable(group_end) && $stable(frame_end), "result changed while stalled")

	// The frame closes only on the last byte of a group.
	`QLBPI_ASSERT_SAME(a_frame_in_group, clk, arst_n, res_valid && frame_end, group_end, "frame end outside group end")

	// The rest of a group follows without a gap.
	`QLBPI_ASSERT_NEXT(a_group_cont, clk, arst_n, res_valid && res_ready && !group_end, res_valid, "group interrupted")

	// After the last byte of a group the output buffer is empty in the next cycle.
	`QLBPI_ASSERT_NEXT(a_group_gap, clk, arst_n, res_valid && res_ready && group_end, !res_valid, "result right after group end")
endmodule

bind quad_lane_bit_pair_interleaver qlbpi_checker u_qlbpi_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.res_valid (res.valid),
	.res_ready (res.ready),
	.out_byte  (res.payload.out_byte),
	.group_end (res.payload.group_end),
	.frame_end (res.payload.frame_end)
);
